// ----- design/vsd_pkg.sv -----
// shared constants and a helper function for the varint stream decoder
package vsd_pkg;

  localparam int BYTE_W     = 8;
  localparam int VALUE_W    = 34;
  localparam int LEN_W      = 3;
  localparam int MAX_BYTES  = 5;
  localparam int HEAD_BITS  = 6;
  localparam int GROUP_BITS = 7;
  localparam int CONT_IDX   = 7;
  localparam int LEN_SAT    = (1 << LEN_W) - 1;

  // byte counter holds up to MAX_BYTES after the increment
  localparam int CNT_W  = $clog2(MAX_BYTES + 1);
  // largest shift is HEAD_BITS + GROUP_BITS * (MAX_BYTES - 2)
  localparam int SH_W   = $clog2(HEAD_BITS + GROUP_BITS * (MAX_BYTES - 2) + 1);
  localparam int DATA_W = ((VALUE_W + LEN_W + 7) / 8) * 8;

  // length saturates at the largest code the field can carry
  function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] n);
    logic [LEN_W-1:0] r;
    if (int'(n) > LEN_SAT) begin
      r = LEN_W'(LEN_SAT);
    end else begin
      r = LEN_W'(n);
    end
    return r;
  endfunction

endpackage

// ----- design/varint_stream_decoder.sv -----
// top level of the varint stream decoder: byte stream in, decoded values out
//
// Takes one encoded byte per clock on the s_ side and emits one result per
// finished value on the m_ side. A byte with bit 7 clear at the start of a
// value is the value itself; otherwise the first byte gives the low 6 bits
// and each following byte adds 7 bits above them, low group first, until a
// byte with bit 7 clear closes the value. If vsd_pkg::MAX_BYTES bytes have
// gone by and the last still has bit 7 set, a result with the error flag,
// value 0 and length MAX_BYTES (saturated at 7) is emitted and the next byte
// starts a new value. Throughput is one byte per clock; the result of a closing byte
// is registered and appears on m_tvalid in the cycle after that byte is accepted.
// The only stall comes from the single result register: while it holds a
// result that m_tready has not taken, s_tready is low. Bits that would land
// at bit 34 or above are dropped. No clearing pass after reset.
module varint_stream_decoder (
  input  logic                         clk,
  input  logic                         rst,
  // byte stream in
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [vsd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] in_byte
  // decoded values out
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [vsd_pkg::DATA_W-1:0]   m_tdata,   // [33:0] value, [36:34] length, rest zero
  output logic [0:0]                   m_tuser    // [0] error
);

  // open value state
  logic [vsd_pkg::VALUE_W-1:0] acc;
  logic [vsd_pkg::VALUE_W-1:0] acc_next;
  logic [vsd_pkg::CNT_W-1:0]   count;
  logic [vsd_pkg::CNT_W-1:0]   count_next;

  // result register
  logic                        out_valid;
  logic [vsd_pkg::VALUE_W-1:0] value;
  logic [vsd_pkg::LEN_W-1:0]   length;
  logic                        error;

  // per-byte result from the combinational step
  logic                        res_valid;
  logic [vsd_pkg::VALUE_W-1:0] res_value;
  logic [vsd_pkg::LEN_W-1:0]   res_length;
  logic                        res_error;

  logic                        accept;
  logic                        more;
  logic [vsd_pkg::CNT_W-1:0]   count_inc;
  logic [vsd_pkg::SH_W-1:0]    shamt;
  logic [vsd_pkg::VALUE_W-1:0] group_shifted;
  logic [vsd_pkg::VALUE_W-1:0] acc_merged;

  // a new byte goes in whenever the result register is free or drains now
  assign s_tready = !rst && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign more      = s_tdata[vsd_pkg::CONT_IDX];
  assign count_inc = count + vsd_pkg::CNT_W'(1);

  // position of the next 7-bit group: 6 + 7 * (count - 1)
  assign shamt = vsd_pkg::SH_W'(vsd_pkg::GROUP_BITS * int'(count) - 1);

  // groups shifted past the top of the value simply fall off
  assign group_shifted = vsd_pkg::VALUE_W'(s_tdata[vsd_pkg::GROUP_BITS-1:0]) << shamt;
  assign acc_merged    = acc | group_shifted;

  always_comb begin
    acc_next   = acc;
    count_next = count;
    res_valid  = 1'b0;
    res_value  = acc_merged;
    res_length = vsd_pkg::sat_len(count_inc);
    res_error  = 1'b0;

    if (count == '0) begin
      if (!more) begin
        // single-byte value
        res_valid  = 1'b1;
        res_value  = vsd_pkg::VALUE_W'(s_tdata);
        res_length = vsd_pkg::LEN_W'(1);
        acc_next   = '0;
      end else begin
        // head byte carries only the low 6 bits
        acc_next   = vsd_pkg::VALUE_W'(s_tdata[vsd_pkg::HEAD_BITS-1:0]);
        count_next = vsd_pkg::CNT_W'(1);
      end
    end else begin
      acc_next   = acc_merged;
      count_next = count_inc;
      if (!more) begin
        // closing byte
        res_valid  = 1'b1;
        acc_next   = '0;
        count_next = '0;
      end
    end

    // byte limit reached with the continuation bit still set
    if (!res_valid && count_next >= vsd_pkg::CNT_W'(vsd_pkg::MAX_BYTES)) begin
      res_valid  = 1'b1;
      res_value  = '0;
      res_length = vsd_pkg::sat_len(count_next);
      res_error  = 1'b1;
      acc_next   = '0;
      count_next = '0;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
    end else if (accept) begin
      acc   <= acc_next;
      count <= count_next;
    end
  end

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      value  <= res_value;
      length <= res_length;
      error  <= res_error;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = vsd_pkg::DATA_W'({length, value});
  assign m_tuser[0] = error;

endmodule

// ----- design/vsd_checker.sv -----
// port-level checks for the varint stream decoder, bound to the top level
module vsd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [vsd_pkg::BYTE_W-1:0] s_tdata,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [vsd_pkg::DATA_W-1:0] m_tdata,
  input logic [0:0]                 m_tuser
);

  logic [vsd_pkg::VALUE_W-1:0] chk_value;
  logic [vsd_pkg::LEN_W-1:0]   chk_len;
  logic                        chk_err;
  logic                        chk_in_req;

  assign chk_value  = m_tdata[vsd_pkg::VALUE_W-1:0];
  assign chk_len    = m_tdata[vsd_pkg::VALUE_W +: vsd_pkg::LEN_W];
  assign chk_err    = m_tuser[0];
  assign chk_in_req = s_tvalid && s_tready && (s_tdata != '0 || s_tdata == '0);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an error result carries value 0 and the full byte limit as length
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && chk_err |->
      chk_value == '0 && chk_len == vsd_pkg::sat_len(vsd_pkg::CNT_W'(vsd_pkg::MAX_BYTES)))
    else $error("malformed error result");

  // a good result has a length between one and the byte limit
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !chk_err |->
      chk_len != '0 && int'(chk_len) <= vsd_pkg::MAX_BYTES)
    else $error("length out of range");

  // a one-byte value fits in seven bits
  a_short: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !chk_err && chk_len == vsd_pkg::LEN_W'(1) |->
      chk_value[vsd_pkg::VALUE_W-1:vsd_pkg::GROUP_BITS] == '0)
    else $error("one-byte value too wide");

  // a result only follows an accepted request
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(chk_in_req))
    else $error("result without a request");

endmodule

bind varint_stream_decoder vsd_checker u_vsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
